// ===== hdl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define BMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent starts in the same cycle as the antecedent.
`define BMR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bmr90_pkg.sv =====
package bmr90_pkg;

    localparam int PIX_W          = 8;
    localparam int LANES          = 8;
    localparam int SEL_W          = $clog2(PIX_W);
    localparam int ROW_W          = 8;
    localparam int COL_W          = 5;
    localparam int CFG_W          = 6;
    localparam int CFG_IDX_W      = 1;
    localparam int SIZE_LIMIT     = 32;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_BYTES   = 1'b0,
        CFG_HEIGHT_GROUPS = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_READ  = 1'b1
    } mode_t;

    // Beat in flight between the lane memories and the output register.
    typedef struct packed {
        logic             valid;
        logic             rd_ok;
        logic             err;
        logic [SEL_W-1:0] bit_idx;
    } stage_t;

endpackage

// ===== hdl/bmr90_lane.sv =====
module bmr90_lane #(
    parameter int ADDR_W = 10
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [bmr90_pkg::PIX_W-1:0] wr_data,
    output logic [bmr90_pkg::PIX_W-1:0] rd_data
);
    import bmr90_pkg::*;

    logic [PIX_W-1:0] mem [2**ADDR_W];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/bmr90_merge.sv =====
module bmr90_merge (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  bmr90_pkg::stage_t                           s1,
    input  logic [bmr90_pkg::LANES-1:0][bmr90_pkg::PIX_W-1:0] lane_data,
    input  logic                                        out_stall,
    output logic                                        advance,
    output logic                                        out_valid,
    output logic [bmr90_pkg::PIX_W-1:0]                 pixels_out,
    output logic                                        range_error
);
    import bmr90_pkg::*;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PIX_W-1:0] pixels_reg;
    logic             err_reg;
    logic [PIX_W-1:0] merged;

    assign advance = s1.valid && (!out_valid_reg || !out_stall);

    // lane k holds row 8*group+k; its pixel lands in bit 7-k
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            merged[PIX_W-1-k] = lane_data[k][s1.bit_idx];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixels_reg <= s1.rd_ok ? merged : '0;
            err_reg    <= s1.err;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixels_out  = pixels_reg;
    assign range_error = err_reg;

endmodule

// ===== hdl/bitmap_rotate_90_core.sv =====
// One-bit bitmap store, written row-wise a byte at a time, read back turned 90 degrees.
// Input channel: in_valid / in_stall carrying mode, row, column_byte, pixels_in.
//   mode write stores pixels_in at input row, byte column; mode read fetches eight
//   pixels of the rotated image at output row, byte column.
// Output channel: out_valid / out_stall carrying pixels_out and range_error; one beat
//   per input beat, in order. Writes and out-of-range beats return zero pixels.
// Config: cfg_we writes cfg_data to register cfg_index (width_bytes, height_groups).
//   The user must write only while the block is idle; the block does not enforce it.
//   Sizes above the store saturate. Throughput: one beat per cycle when not stalled.
// Eight row-interleaved lane memories, one byte port each: a write touches one lane, a
//   read takes one byte from every lane and merges.
// Reset: clears the pipeline and sets both sizes to 32; pixel contents stay undefined
//   until written, and no clearing pass runs.
// Stall: a stalled result holds in the output register; one more beat may sit in the
//   memory stage, after which in_stall rises until the output moves.
module bitmap_rotate_90_core #(
    parameter int MAX_WIDTH  = bmr90_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmr90_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bmr90_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmr90_pkg::CFG_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [bmr90_pkg::ROW_W-1:0]     row,
    input  logic [bmr90_pkg::COL_W-1:0]     column_byte,
    input  logic [bmr90_pkg::PIX_W-1:0]     pixels_in,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [bmr90_pkg::PIX_W-1:0]     pixels_out,
    output logic                            range_error
);
    import bmr90_pkg::*;

    localparam int WB_CAP = (MAX_WIDTH / PIX_W < SIZE_LIMIT) ? MAX_WIDTH / PIX_W : SIZE_LIMIT;
    localparam int HG_CAP = (MAX_HEIGHT / LANES < SIZE_LIMIT) ? MAX_HEIGHT / LANES
                                                               : SIZE_LIMIT;
    localparam int CB_W   = (WB_CAP > 1) ? $clog2(WB_CAP) : 1;
    localparam int GB_W   = (HG_CAP > 1) ? $clog2(HG_CAP) : 1;
    localparam int ADDR_W = CB_W + GB_W;
    localparam int GRP_W  = ROW_W - SEL_W;
    localparam logic [CFG_W-1:0] WB_CAP_V = CFG_W'(WB_CAP);
    localparam logic [CFG_W-1:0] HG_CAP_V = CFG_W'(HG_CAP);

    logic [CFG_W-1:0] width_bytes_reg;
    logic [CFG_W-1:0] height_groups_reg;
    logic [CFG_W-1:0] wb_eff;
    logic [CFG_W-1:0] hg_eff;

    stage_t s1_reg;
    stage_t s1_next;

    logic                          accept;
    logic                          advance;
    logic                          is_read;
    logic                          err;
    logic [GRP_W-1:0]              row_grp;
    logic [CFG_W-1:0]              col_rd;
    logic [GB_W-1:0]               addr_grp;
    logic [CB_W-1:0]               addr_col;
    logic [ADDR_W-1:0]             addr;
    logic [LANES-1:0]              wr_en;
    logic                          rd_en;
    logic [LANES-1:0][PIX_W-1:0]   lane_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_bytes_reg   <= CFG_W'(SIZE_LIMIT);
            height_groups_reg <= CFG_W'(SIZE_LIMIT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_WIDTH_BYTES:   width_bytes_reg   <= cfg_data;
                CFG_HEIGHT_GROUPS: height_groups_reg <= cfg_data;
            endcase
        end
    end

    assign wb_eff = (width_bytes_reg > WB_CAP_V) ? WB_CAP_V : width_bytes_reg;
    assign hg_eff = (height_groups_reg > HG_CAP_V) ? HG_CAP_V : height_groups_reg;

    assign in_stall = s1_reg.valid && !advance;
    assign accept   = in_valid && !in_stall;
    assign is_read  = (mode == MODE_READ);
    assign row_grp  = row[ROW_W-1:SEL_W];

    always_comb
    begin
        if (is_read)
        begin
            err = (CFG_W'(row_grp) >= wb_eff) || (CFG_W'(column_byte) >= hg_eff);
        end
        else
        begin
            err = (CFG_W'(row_grp) >= hg_eff) || (CFG_W'(column_byte) >= wb_eff);
        end
    end

    // rotated row r maps to input byte column wb-1-r/8, bit r%8 of that byte
    assign col_rd = wb_eff - CFG_W'(1) - CFG_W'(row_grp);

    always_comb
    begin
        if (is_read)
        begin
            addr_grp = column_byte[GB_W-1:0];
            addr_col = col_rd[CB_W-1:0];
        end
        else
        begin
            addr_grp = row_grp[GB_W-1:0];
            addr_col = column_byte[CB_W-1:0];
        end
    end

    assign addr  = {addr_grp, addr_col};
    assign rd_en = accept && is_read && !err;

    always_comb
    begin
        s1_next = s1_reg;
        if (accept)
        begin
            s1_next.valid   = 1'b1;
            s1_next.rd_ok   = is_read && !err;
            s1_next.err     = err;
            s1_next.bit_idx = row[SEL_W-1:0];
        end
        else if (advance)
        begin
            s1_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        assign wr_en[k] = accept && !is_read && !err && (row[SEL_W-1:0] == SEL_W'(k));

        bmr90_lane #(
            .ADDR_W (ADDR_W)
        ) u_lane (
            .clk     (clk),
            .wr_en   (wr_en[k]),
            .rd_en   (rd_en),
            .addr    (addr),
            .wr_data (pixels_in),
            .rd_data (lane_data[k])
        );
    end

    bmr90_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .s1          (s1_reg),
        .lane_data   (lane_data),
        .out_stall   (out_stall),
        .advance     (advance),
        .out_valid   (out_valid),
        .pixels_out  (pixels_out),
        .range_error (range_error)
    );

endmodule

// ===== hdl/bmr90_checker.sv =====
`include "assert_macros.svh"

module bmr90_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [bmr90_pkg::PIX_W-1:0] pixels_out,
    input logic                        range_error
);

    // stalled result beat holds
    `BMR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pixels_out) && $stable(range_error), "stalled output beat changed")

    // error beats carry no pixels
    `BMR_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && range_error, pixels_out == '0, "error beat with pixels")

    // input backs off only when the output is full and stalled
    `BMR_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled with free output")

    // out_valid follows an accepted beat
    `BMR_ASSERT_NOW(a_latency, clk, rst_n, in_valid && !in_stall, ##2 out_valid, "accepted beat lost")

endmodule

bind bitmap_rotate_90_core bmr90_checker u_bmr90_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixels_out  (pixels_out),
    .range_error (range_error)
);
